// ===== hdl/led_matrix_row_scanner_top_defines.svh =====
// ----------------------------------------------------------------------------
// LED matrix row scanner - assertion macros
// Shared helpers for the concurrent checks of the row scanner.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_ROW_SCANNER_TOP_DEFINES_SVH
`define LED_MATRIX_ROW_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define LMRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define LMRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lmrs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scanner - package
// Operation codes, result kinds and the decoded command record.
// ----------------------------------------------------------------------------
`default_nettype none

package lmrs_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SCAN  = 2'd2,
    OP_BLANK = 2'd3
  } op_e;

  // Result kinds
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_SERIAL = 1'b1;

  // Shift word layout: row field in the low bits, columns above
  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned ROW_FIELD_BITS = 7;
  localparam int unsigned COL_FIELD_BITS = WORD_BITS - ROW_FIELD_BITS;

  localparam int unsigned PIX_W = 8;

  // Decoded request handed from front to back
  typedef struct packed {
    op_e              op;
    logic             in_range;
    logic [PIX_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/led_matrix_row_scanner_top.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scanner - top level
// Frame store for a multiplexed LED matrix with serial row-word output.
// ----------------------------------------------------------------------------
// A write request gives no result. A read request gives one result, which
// passes the issue stage and the result register after it leaves the command
// queue. A scan tick or blank gives 32 serial results, one per cycle when pop
// keeps up, so one tick occupies the back end until its last bit issues; the
// single frame-store read port supplies one column per column bit of a scan,
// read in step with the shifting. The front end and a two-entry command queue
// keep taking requests while a word is being shifted. The frame store clears
// at reset through a per-pixel written flag, so there is no clearing pass.
`default_nettype none

module led_matrix_row_scanner_top import lmrs_pkg::*; #(
  parameter int unsigned NUM_COLUMNS = 25,
  parameter int unsigned NUM_ROWS    = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [1:0]       op_i,
  input  wire logic [4:0]       column_i,
  input  wire logic [2:0]       row_sel_i,
  input  wire logic [PIX_W-1:0] value_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic                  kind_o,
  output logic [PIX_W-1:0]      pixel_value_o,
  output logic                  serial_bit_o,
  output logic [2:0]            row_index_o,
  output logic                  last_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i
);

`include "led_matrix_row_scanner_top_defines.svh"

  localparam int unsigned DEPTH  = NUM_COLUMNS * NUM_ROWS;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned Q_W    = AW + $bits(cmd_t);

  logic          fe_vld;
  cmd_t          fe_cmd;
  logic [AW-1:0] fe_addr;
  logic          q_full, q_empty, q_pop;
  logic [Q_W-1:0] q_rdata;
  cmd_t          q_cmd;
  logic [AW-1:0] q_addr;
  logic          out_vld;

  // Request intake and decode
  lmrs_front #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS),
    .AW          (AW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .op_i      (op_i),
    .column_i  (column_i),
    .row_sel_i (row_sel_i),
    .value_i   (value_i),
    .cmd_vld_o (fe_vld),
    .cmd_o     (fe_cmd),
    .addr_o    (fe_addr),
    .q_full_i  (q_full)
  );

  // Decoupling queue
  lmrs_cmd_fifo #(
    .DATA_W (Q_W)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_vld),
    .wdata_i ({fe_addr, fe_cmd}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign q_addr = q_rdata[Q_W-1 -: AW];
  assign q_cmd  = cmd_t'(q_rdata[$bits(cmd_t)-1:0]);

  // Frame store and scan engine
  lmrs_back #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS),
    .AW          (AW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_vld_i       (!q_empty),
    .q_cmd_i       (q_cmd),
    .q_addr_i      (q_addr),
    .q_pop_o       (q_pop),
    .out_vld_o     (out_vld),
    .pop_i         (pop),
    .kind_o        (kind_o),
    .pixel_value_o (pixel_value_o),
    .serial_bit_o  (serial_bit_o),
    .row_index_o   (row_index_o),
    .last_o        (last_o)
  );

  assign empty = !out_vld;

  // Checks
  `LMRS_ASSERT_NOW(a_row_in_range, !empty, row_index_o < 3'(NUM_ROWS), "row index beyond rows")
  `LMRS_ASSERT_NOW(a_read_shape, !empty && kind_o == KIND_READ, last_o && !serial_bit_o && row_index_o == 3'd0, "malformed read result")
  `LMRS_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "command queue popped while empty")
  `LMRS_ASSERT_NEXT(a_full_holds, full && !pop, fe_vld, "front stage lost request while queue full")

endmodule

`default_nettype wire

// ===== hdl/lmrs_front.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scanner - front end
// Accepts requests, range-checks the pixel address and forms the store index.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_front import lmrs_pkg::*; #(
  parameter int unsigned NUM_COLUMNS = 25,
  parameter int unsigned NUM_ROWS    = 7,
  parameter int unsigned AW          = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [4:0]       column_i,
  input  wire logic [2:0]       row_sel_i,
  input  wire logic [PIX_W-1:0] value_i,
  output logic                  cmd_vld_o,
  output cmd_t                  cmd_o,
  output logic [AW-1:0]         addr_o,
  input  wire logic             q_full_i
);

  logic          vld_q, vld_d;
  cmd_t          cmd_q;
  logic [AW-1:0] addr_q;
  logic          accept;
  logic          hand_off;
  logic          in_range;

  // Hand-off to the command queue and input acceptance
  assign hand_off = vld_q && !q_full_i;
  assign accept   = push_i && !full_o;
  assign full_o   = vld_q && q_full_i;

  assign in_range = ({1'b0, column_i} < 6'(NUM_COLUMNS)) && (row_sel_i < 3'(NUM_ROWS));

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (hand_off) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Decode: op, range flag and linear store index (row-major)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op       <= op_e'(op_i);
      cmd_q.in_range <= in_range;
      cmd_q.value    <= value_i;
      addr_q         <= AW'(row_sel_i) * AW'(NUM_COLUMNS) + AW'(column_i);
    end
  end

  assign cmd_vld_o = vld_q;
  assign cmd_o     = cmd_q;
  assign addr_o    = addr_q;

endmodule

`default_nettype wire

// ===== hdl/lmrs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scanner - command queue
// Two-entry queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_cmd_fifo import lmrs_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      rdata_o,
  output logic                   empty_o
);

  logic [DATA_W-1:0] store_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = store_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hdl/lmrs_back.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scanner - back end
// Frame store, scan row, serial bit generator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_back import lmrs_pkg::*; #(
  parameter int unsigned NUM_COLUMNS = 25,
  parameter int unsigned NUM_ROWS    = 7,
  parameter int unsigned AW          = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  input  wire logic             q_vld_i,
  input  wire cmd_t             q_cmd_i,
  input  wire logic [AW-1:0]    q_addr_i,
  output logic                  q_pop_o,
  output logic                  out_vld_o,
  input  wire logic             pop_i,
  output logic                  kind_o,
  output logic [PIX_W-1:0]      pixel_value_o,
  output logic                  serial_bit_o,
  output logic [2:0]            row_index_o,
  output logic                  last_o
);

  localparam int unsigned DEPTH = NUM_COLUMNS * NUM_ROWS;

  // Frame store with a per-pixel written flag (unwritten reads as zero)
  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] wr_flag_q;
  logic [PIX_W-1:0] rd_data_q;
  logic             rd_hit_q;
  logic             mem_we;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  // Configuration and scan state
  logic       inv_q;
  logic [2:0] scan_row_q;

  // Word generator
  logic          gen_busy_q;
  logic          gen_scan_q;
  logic [4:0]    bit_cnt_q;
  logic [2:0]    gen_row_q;
  logic [AW-1:0] gen_base_q;
  logic          gen_start, gen_done;
  logic [4:0]    col;
  logic [4:0]    row_bit;

  // Issue stage (read in flight)
  logic       s1_vld_q;
  logic       s1_kind_q, s1_mem_q, s1_bit_q, s1_last_q;
  logic [2:0] s1_row_q;
  logic       iss, iss_kind, iss_mem, iss_bit, iss_last;
  logic [2:0] iss_row;
  logic       slot_free, s1_adv, out_rdy;

  // Result register
  logic             out_vld_q;
  logic             out_kind_q, out_bit_q, out_last_q;
  logic [PIX_W-1:0] out_pix_q;
  logic [2:0]       out_row_q;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_serial;

  assign out_rdy   = !out_vld_q || pop_i;
  assign s1_adv    = s1_vld_q && out_rdy;
  assign slot_free = !s1_vld_q || out_rdy;

  // Bit k of the stream: columns 24..0 first, then row bits 6..0
  assign col     = 5'(COL_FIELD_BITS - 1) - bit_cnt_q;
  assign row_bit = 5'(WORD_BITS - 1) - bit_cnt_q;

  // Dispatch: generator has priority, otherwise take the next command
  always_comb begin
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = q_addr_i;
    iss       = 1'b0;
    iss_kind  = KIND_SERIAL;
    iss_mem   = 1'b0;
    iss_bit   = 1'b0;
    iss_last  = 1'b0;
    iss_row   = gen_row_q;
    gen_start = 1'b0;
    gen_done  = 1'b0;
    if (gen_busy_q) begin
      if (slot_free) begin
        iss      = 1'b1;
        iss_last = (bit_cnt_q == 5'(WORD_BITS - 1));
        gen_done = iss_last;
        if (!gen_scan_q) begin
          iss_bit = 1'b1;
        end else if (bit_cnt_q < 5'(COL_FIELD_BITS)) begin
          if ({1'b0, col} < 6'(NUM_COLUMNS)) begin
            rd_en   = 1'b1;
            rd_addr = gen_base_q + AW'(col);
            iss_mem = 1'b1;
          end else begin
            iss_bit = inv_q;
          end
        end else begin
          iss_bit = (row_bit == {2'b00, gen_row_q});
        end
      end
    end else if (q_vld_i) begin
      case (q_cmd_i.op)
        OP_WRITE: begin
          q_pop_o = 1'b1;
          mem_we  = q_cmd_i.in_range;
        end
        OP_READ: begin
          if (slot_free) begin
            q_pop_o  = 1'b1;
            iss      = 1'b1;
            iss_kind = KIND_READ;
            iss_mem  = q_cmd_i.in_range;
            rd_en    = q_cmd_i.in_range;
            iss_last = 1'b1;
            iss_row  = 3'd0;
          end
        end
        default: begin
          q_pop_o   = 1'b1;
          gen_start = 1'b1;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q      <= 1'b1;
      scan_row_q <= 3'd0;
      gen_busy_q <= 1'b0;
      bit_cnt_q  <= 5'd0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      wr_flag_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        inv_q <= cfg_wdata_i;
      end
      if (gen_start) begin
        gen_busy_q <= 1'b1;
        bit_cnt_q  <= 5'd0;
      end else if (iss && gen_busy_q) begin
        bit_cnt_q <= bit_cnt_q + 5'd1;
        if (gen_done) begin
          gen_busy_q <= 1'b0;
          if (gen_scan_q) begin
            scan_row_q <= (scan_row_q == 3'(NUM_ROWS - 1)) ? 3'd0 : scan_row_q + 3'd1;
          end
        end
      end
      if (iss) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
      if (mem_we) begin
        wr_flag_q[q_addr_i] <= 1'b1;
      end
    end
  end

  // Generator payload, latched at the start of a word
  always_ff @(posedge clk_i) begin
    if (gen_start) begin
      gen_scan_q <= (q_cmd_i.op == OP_SCAN);
      gen_row_q  <= scan_row_q;
      gen_base_q <= AW'(scan_row_q) * AW'(NUM_COLUMNS);
    end
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[q_addr_i] <= q_cmd_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_hit_q  <= wr_flag_q[rd_addr];
    end
  end

  // Issue stage payload
  always_ff @(posedge clk_i) begin
    if (iss) begin
      s1_kind_q <= iss_kind;
      s1_mem_q  <= iss_mem;
      s1_bit_q  <= iss_bit;
      s1_last_q <= iss_last;
      s1_row_q  <= iss_row;
    end
  end

  // Pixel resolved from the read port; never-written pixels read as zero
  assign s1_pix    = (s1_mem_q && rd_hit_q) ? rd_data_q : '0;
  assign s1_serial = s1_mem_q ? ((s1_pix != '0) ^ inv_q) : s1_bit_q;

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_kind_q <= s1_kind_q;
      out_pix_q  <= (s1_kind_q == KIND_READ) ? s1_pix : '0;
      out_bit_q  <= (s1_kind_q == KIND_READ) ? 1'b0 : s1_serial;
      out_row_q  <= s1_row_q;
      out_last_q <= s1_last_q;
    end
  end

  assign out_vld_o     = out_vld_q;
  assign kind_o        = out_kind_q;
  assign pixel_value_o = out_pix_q;
  assign serial_bit_o  = out_bit_q;
  assign row_index_o   = out_row_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire
